FILE: design/mstl_pkg.sv
`default_nettype none
package mstl_pkg;

	localparam int MaxWindows = 64;
	localparam int ResultCap  = 64;
	localparam int CountCap   = (MaxWindows < ResultCap) ? MaxWindows : ResultCap;

	localparam int RatioMin = 100;
	localparam int RatioMax = 900;
	localparam int RatioDen = 1000;

	// floor(p / 1000) as ((p >> 3) * ceil(2^29 / 125)) >> 29, exact for p below 2^25
	localparam logic [22:0] RatioRecip = 23'd4294968;
	localparam int          RatioShift = 29;

	localparam int DivW   = 25;
	localparam int DivsW  = 10;
	localparam int DivCntW = $clog2(DivW);

	localparam int FifoDepth = 2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_GEOM  = 2'd2,
		ST_COLLAPSED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_GAP    = 3'd4,
		REG_RATIO  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        width;
		logic [14:0]        height;
		logic [11:0]        gap;
		logic [9:0]         ratio;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DivW-1:0]   dividend;
		logic [DivsW-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DivW-1:0]   quotient;
	} div_rsp_t;

	typedef struct packed {
		status_t            status;
		logic [6:0]         count;
		logic signed [17:0] ix;
		logic signed [17:0] iy;
		logic [14:0]        w0;
		logic [14:0]        h0;
		logic signed [17:0] sx;
		logic [14:0]        sw;
		logic [14:0]        sh;
		logic [11:0]        gap;
	} desc_t;

	typedef struct packed {
		status_t            status;
		logic               last;
		logic [5:0]         idx;
		logic [14:0]        h;
		logic [14:0]        w;
		logic signed [17:0] y;
		logic signed [17:0] x;
	} res_t;

endpackage
`default_nettype wire

FILE: design/master_stack_tile_layout_core.sv
`default_nettype none
// Master/stack tiler. Each input item carries a window count (saturated to 64) and yields
// one result item per window in slot order, slot 0 being the left master column, the others
// equal-height rows of the right stack column; an empty count, bad geometry or a collapsed
// column or row yields a single item with a nonzero status and last set. The front takes an
// item, does setup and then works out the master width (a reciprocal multiply stands
// in for the divide by 1000), then, for two or more windows and no error, runs the row
// height through a restoring divider at one quotient bit per cycle; it takes no new count
// until it has pushed the layout into the queue. Layouts then wait in a two-deep queue
// while the back emits one result per cycle when the output side is ready, pausing
// between layouts to take the next one, so the front works on the next count during
// emission. Configuration registers sit at byte addresses 0 (left), 4 (top), 8 (width),
// 12 (height), 16 (gap) and 20 (master ratio in thousandths, clamped to 100..900); the
// user must write them only while idle, which the block itself does not enforce.
module master_stack_tile_layout_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [6:0] window_count
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [17:0] rect_x, [35:18] rect_y, [50:36] rect_w, [65:51] rect_h, [71:66] window_index
	output logic [71:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // [1:0] status
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	mstl_pkg::cfg_t     cfg_q;
	mstl_pkg::reg_idx_t ridx;
	logic               wr;

	mstl_pkg::div_req_t div_req;
	mstl_pkg::div_rsp_t div_rsp;
	logic               q_full;
	logic               q_push;
	mstl_pkg::desc_t    q_wdata;
	logic               q_pop;
	mstl_pkg::desc_t    q_rdata;
	logic               q_valid;
	mstl_pkg::res_t     res;

	assign pready = 1'b1;
	assign ridx   = mstl_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= '0;
			cfg_q.top    <= '0;
			cfg_q.width  <= 15'd1024;
			cfg_q.height <= 15'd768;
			cfg_q.gap    <= '0;
			cfg_q.ratio  <= 10'd500;
		end else if (wr) begin
			unique case (ridx)
				mstl_pkg::REG_LEFT:   cfg_q.left   <= pwdata[15:0];
				mstl_pkg::REG_TOP:    cfg_q.top    <= pwdata[15:0];
				mstl_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[14:0];
				mstl_pkg::REG_HEIGHT: cfg_q.height <= pwdata[14:0];
				mstl_pkg::REG_GAP:    cfg_q.gap    <= pwdata[11:0];
				mstl_pkg::REG_RATIO:  cfg_q.ratio  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			mstl_pkg::REG_LEFT:   prdata = {{16{cfg_q.left[15]}}, cfg_q.left};
			mstl_pkg::REG_TOP:    prdata = {{16{cfg_q.top[15]}}, cfg_q.top};
			mstl_pkg::REG_WIDTH:  prdata = {17'b0, cfg_q.width};
			mstl_pkg::REG_HEIGHT: prdata = {17'b0, cfg_q.height};
			mstl_pkg::REG_GAP:    prdata = {20'b0, cfg_q.gap};
			mstl_pkg::REG_RATIO:  prdata = {22'b0, cfg_q.ratio};
			default:              prdata = '0;
		endcase
	end

	mstl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_count (s_axis_tdata[6:0]),
		.cfg      (cfg_q),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_wdata)
	);

	mstl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mstl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	mstl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_desc    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.idx, res.h, res.w, res.y, res.x};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

FILE: design/mstl_div.sv
`default_nettype none
module mstl_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mstl_pkg::div_req_t req,
	output mstl_pkg::div_rsp_t      rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [mstl_pkg::DivCntW-1:0]      cnt_q;
	logic [mstl_pkg::DivW-1:0]         quo_q;
	logic [mstl_pkg::DivsW-1:0]        rem_q;
	logic [mstl_pkg::DivsW-1:0]        dvs_q;
	logic [mstl_pkg::DivsW:0]          trial;
	logic                              ge;
	logic [mstl_pkg::DivsW:0]          diff;

	assign trial = {rem_q, quo_q[mstl_pkg::DivW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mstl_pkg::DivCntW'(mstl_pkg::DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mstl_pkg::DivW-2:0], ge};
			rem_q <= ge ? diff[mstl_pkg::DivsW-1:0] : trial[mstl_pkg::DivsW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

FILE: design/mstl_front.sv
`default_nettype none
module mstl_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [6:0]         in_count,
	input  wire mstl_pkg::cfg_t     cfg,
	output mstl_pkg::div_req_t      div_req,
	input  wire mstl_pkg::div_rsp_t div_rsp,
	input  wire logic               q_full,
	output logic                    q_push,
	output mstl_pkg::desc_t         q_desc
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_PREP = 5'b00010,
		F_DIVM = 5'b00100,
		F_DIVS = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	fstate_t              state_q;
	logic                 start_q;
	logic [6:0]           count_q;
	mstl_pkg::status_t    stat_q;
	logic signed [17:0]   ix_q;
	logic signed [17:0]   iy_q;
	logic [14:0]          iw_q;
	logic [14:0]          ih_q;
	logic [14:0]          avail_q;
	logic [21:0]          prod_q;
	logic [14:0]          num_q;
	logic [14:0]          mw_q;
	logic [14:0]          sw_q;
	logic [14:0]          sh_q;

	logic signed [17:0]   ix_c;
	logic signed [17:0]   iy_c;
	logic signed [16:0]   iw_c;
	logic signed [16:0]   ih_c;
	logic signed [16:0]   avail_c;
	logic signed [19:0]   num_c;
	logic [9:0]           ratio_c;
	logic [5:0]           sc_c;
	logic [5:0]           scm1_c;
	logic [17:0]          rowgap_c;
	logic [24:0]          prod_c;
	logic [43:0]          mprod_c;
	logic [14:0]          mw_c;
	logic                 single_c;
	logic                 bad_c;
	logic                 coll_c;
	mstl_pkg::status_t    stat_c;
	logic [14:0]          q_lo;
	logic [6:0]           cnt_sat;

	assign in_ready = state_q == F_IDLE;
	assign cnt_sat  = (in_count > 7'(mstl_pkg::CountCap)) ? 7'(mstl_pkg::CountCap) : in_count;

	assign ix_c    = $signed({{2{cfg.left[15]}}, cfg.left}) + $signed({6'b0, cfg.gap});
	assign iy_c    = $signed({{2{cfg.top[15]}}, cfg.top}) + $signed({6'b0, cfg.gap});
	assign iw_c    = $signed({2'b0, cfg.width}) - $signed({4'b0, cfg.gap, 1'b0});
	assign ih_c    = $signed({2'b0, cfg.height}) - $signed({4'b0, cfg.gap, 1'b0});
	assign avail_c = iw_c - $signed({5'b0, cfg.gap});
	assign ratio_c = (cfg.ratio < 10'(mstl_pkg::RatioMin)) ? 10'(mstl_pkg::RatioMin) :
	                 (cfg.ratio > 10'(mstl_pkg::RatioMax)) ? 10'(mstl_pkg::RatioMax) : cfg.ratio;
	// stack row count; a count of 64 gives 63, which fits the six bits
	assign sc_c     = 6'(count_q - 7'd1);
	assign scm1_c   = sc_c - 6'd1;
	assign rowgap_c = {12'b0, scm1_c} * {6'b0, cfg.gap};
	assign num_c    = $signed({{3{ih_c[16]}}, ih_c}) - $signed({2'b0, rowgap_c});
	assign prod_c   = {10'b0, avail_c[14:0]} * {15'b0, ratio_c};
	assign mprod_c  = {22'b0, prod_q} * {21'b0, mstl_pkg::RatioRecip};
	assign mw_c     = mprod_c[mstl_pkg::RatioShift +: 15];
	assign single_c = count_q == 7'd1;
	assign bad_c    = (cfg.width == '0) || (cfg.height == '0) ||
	                  iw_c[16] || (iw_c == '0) || ih_c[16] || (ih_c == '0);
	assign coll_c   = avail_c[16] || (avail_c == '0) || num_c[19] || (num_c == '0);

	always_comb begin
		if (count_q == '0)
			stat_c = mstl_pkg::ST_EMPTY;
		else if (bad_c)
			stat_c = mstl_pkg::ST_BAD_GEOM;
		else if (!single_c && coll_c)
			stat_c = mstl_pkg::ST_COLLAPSED;
		else
			stat_c = mstl_pkg::ST_OK;
	end

	assign q_lo = div_rsp.quotient[14:0];

	assign div_req.start    = start_q;
	assign div_req.dividend = {10'b0, num_q};
	assign div_req.divisor  = {4'b0, sc_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (in_valid)
						state_q <= F_PREP;
				end
				F_PREP: begin
					if (stat_c != mstl_pkg::ST_OK || single_c)
						state_q <= F_PUSH;
					else
						state_q <= F_DIVM;
				end
				F_DIVM: begin
					if (mw_c == '0 || avail_q <= mw_c) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_DIVS;
						start_q <= 1'b1;
					end
				end
				F_DIVS: begin
					if (div_rsp.done)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid)
			count_q <= cnt_sat;
		if (state_q == F_PREP) begin
			stat_q  <= stat_c;
			ix_q    <= ix_c;
			iy_q    <= iy_c;
			iw_q    <= iw_c[14:0];
			ih_q    <= ih_c[14:0];
			avail_q <= avail_c[14:0];
			prod_q  <= prod_c[24:3];
			num_q   <= num_c[14:0];
		end
		if (state_q == F_DIVM) begin
			mw_q <= mw_c;
			sw_q <= avail_q - mw_c;
			if (mw_c == '0 || avail_q <= mw_c)
				stat_q <= mstl_pkg::ST_COLLAPSED;
		end
		if (state_q == F_DIVS && div_rsp.done) begin
			sh_q <= q_lo;
			if (div_rsp.quotient == '0)
				stat_q <= mstl_pkg::ST_COLLAPSED;
		end
	end

	assign q_push        = (state_q == F_PUSH) && !q_full;
	assign q_desc.status = stat_q;
	assign q_desc.count  = count_q;
	assign q_desc.ix     = ix_q;
	assign q_desc.iy     = iy_q;
	assign q_desc.w0     = single_c ? iw_q : mw_q;
	assign q_desc.h0     = ih_q;
	assign q_desc.sx     = ix_q + $signed({3'b0, mw_q}) + $signed({6'b0, cfg.gap});
	assign q_desc.sw     = sw_q;
	assign q_desc.sh     = sh_q;
	assign q_desc.gap    = cfg.gap;

endmodule
`default_nettype wire

FILE: design/mstl_fifo.sv
`default_nettype none
module mstl_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mstl_pkg::desc_t wdata,
	output logic                 full,
	input  wire logic            pop,
	output mstl_pkg::desc_t      rdata,
	output logic                 valid
);

	localparam int PtrW = $clog2(mstl_pkg::FifoDepth);

	mstl_pkg::desc_t     mem_q [mstl_pkg::FifoDepth];
	logic [PtrW-1:0]     wp_q;
	logic [PtrW-1:0]     rp_q;
	logic [PtrW:0]       cnt_q;

	assign full  = cnt_q == (PtrW+1)'(mstl_pkg::FifoDepth);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PtrW'(mstl_pkg::FifoDepth - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PtrW'(mstl_pkg::FifoDepth - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("layout queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("layout queue count slip");

endmodule
`default_nettype wire

FILE: design/mstl_back.sv
`default_nettype none
module mstl_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire mstl_pkg::desc_t q_desc,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output mstl_pkg::res_t       out_res
);

	logic               active_q;
	mstl_pkg::desc_t    d_q;
	logic [6:0]         slot_q;
	logic signed [17:0] row_q;
	logic               ovalid_q;
	mstl_pkg::res_t     ores_q;

	logic               load;
	logic               err;
	logic               first;
	logic               item_last;
	mstl_pkg::res_t     res_c;

	assign load      = !ovalid_q || out_ready;
	assign q_pop     = !active_q && q_valid;
	assign err       = d_q.status != mstl_pkg::ST_OK;
	assign first     = slot_q == '0;
	assign item_last = err || (slot_q == d_q.count - 7'd1);

	always_comb begin
		res_c.status = d_q.status;
		res_c.last   = item_last;
		res_c.idx    = slot_q[5:0];
		res_c.x      = first ? d_q.ix : d_q.sx;
		res_c.y      = first ? d_q.iy : row_q;
		res_c.w      = first ? d_q.w0 : d_q.sw;
		res_c.h      = first ? d_q.h0 : d_q.sh;
		if (err) begin
			res_c.idx = '0;
			res_c.x   = '0;
			res_c.y   = '0;
			res_c.w   = '0;
			res_c.h   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop)
				active_q <= 1'b1;
			else if (active_q && load && item_last)
				active_q <= 1'b0;
			if (active_q && load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			d_q    <= q_desc;
			slot_q <= '0;
			row_q  <= q_desc.iy;
		end else if (active_q && load) begin
			slot_q <= slot_q + 1'b1;
			if (!first)
				row_q <= row_q + $signed({3'b0, d_q.sh}) + $signed({6'b0, d_q.gap});
		end
		if (active_q && load)
			ores_q <= res_c;
	end

	assign out_valid = ovalid_q;
	assign out_res   = ores_q;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && ores_q.status != mstl_pkg::ST_OK) |-> (ores_q.last && ores_q.idx == '0))
		else $error("error item not a lone result");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && out_ready && !ores_q.last) |=> ovalid_q)
		else $error("run ended without last");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (active_q && slot_q == '0))
		else $error("layout taken while busy");

endmodule
`default_nettype wire
